[design/bve_pkg.sv]
// Shared constants, codes and structures of the bounded vector engine.
package bve_pkg;

  localparam int CAPACITY = 256;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [3:0] {
    REQ_APPEND  = 4'd0,
    REQ_POP     = 4'd1,
    REQ_FRONT   = 4'd2,
    REQ_BACK    = 4'd3,
    REQ_GET     = 4'd4,
    REQ_SET     = 4'd5,
    REQ_INSERT  = 4'd6,
    REQ_REMOVE  = 4'd7,
    REQ_REVERSE = 4'd8,
    REQ_CLEAR   = 4'd9,
    REQ_FIND    = 4'd10
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_LOAD,
    CELL_INS,
    CELL_REM,
    CELL_ROT
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAVE,
    S_REV,
    S_OUT
  } state_e;

  typedef struct packed {
    cell_op_e                op;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        n;
    logic                    find;
    logic [ELEM_W-1:0]       key;
  } cell_ctl_t;

  typedef struct packed {
    logic                    valid;
    logic                    hit;
    logic [ELEM_W-1:0]       data;
    logic [IDX_W-1:0]        idx;
  } carry_t;

endpackage

[design/bve_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface bve_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] req_type;
  logic [7:0] position;
  logic [31:0] data_word;
  modport source (output valid, req_type, position, data_word, input ready);
  modport sink (input valid, req_type, position, data_word, output ready);
endinterface

interface bve_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_word;
  logic [7:0]  found_position;
  logic [2:0]  status;
  logic [8:0]  count;
  modport source (output valid, read_word, found_position, status, count, input ready);
  modport sink (input valid, read_word, found_position, status, count, output ready);
endinterface

[design/bve_cell.sv]
// One storage cell of the chain: holds one element and one stage of the search wave.
module bve_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  bve_pkg::cell_ctl_t         ctl,
  input  logic [bve_pkg::IDX_W-1:0]  my_idx,
  input  logic [bve_pkg::ELEM_W-1:0] left_w,
  input  logic [bve_pkg::ELEM_W-1:0] right_w,
  input  logic [bve_pkg::ELEM_W-1:0] first_w,
  input  bve_pkg::carry_t            carry_in,
  output logic [bve_pkg::ELEM_W-1:0] word,
  output bve_pkg::carry_t            carry_out
);
  import bve_pkg::*;

  logic [CMP_W-1:0] idx_c;
  logic             live;
  logic             hit_here;
  carry_t           carry_next;

  assign idx_c    = CMP_W'(my_idx);
  assign live     = idx_c < ctl.n;
  assign hit_here = live && (ctl.find ? (word == ctl.key) : (idx_c == ctl.pos));

  always_comb begin
    carry_next.valid = carry_in.valid;
    carry_next.hit   = carry_in.hit | (carry_in.valid & hit_here);
    carry_next.data  = carry_in.hit ? carry_in.data : word;
    carry_next.idx   = carry_in.hit ? carry_in.idx : my_idx;
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD: begin
        if (idx_c == ctl.pos) word <= ctl.key;
      end
      CELL_INS: begin
        if (idx_c > ctl.pos) word <= left_w;
        else if (idx_c == ctl.pos) word <= ctl.key;
      end
      CELL_REM: begin
        if (idx_c >= ctl.pos) word <= right_w;
      end
      CELL_ROT: begin
        // Rotate the prefix up to pos left by one place.
        if (idx_c < ctl.pos) word <= right_w;
        else if (idx_c == ctl.pos) word <= first_w;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.valid <= 1'b0;
      carry_out.hit   <= 1'b0;
    end else begin
      carry_out.valid <= carry_next.valid;
      carry_out.hit   <= carry_next.hit;
    end
    carry_out.data <= carry_next.data;
    carry_out.idx  <= carry_next.idx;
  end

endmodule

[design/bounded_vector_engine_top.sv]
// Top level of the bounded vector engine: controller and the chain of cells.
//
// Usage: one request transfer on req gives exactly one response transfer on rsp.
// The engine works on one request at a time; req.ready is high only when idle.
// Path from request transfer to response valid:
//   append, pop-less updates (set, insert, remove), clear, errors: S_EXEC, then S_OUT
//   pop, front, back, get, find: S_EXEC, then S_WAVE while the search wave
//     walks the cell chain one cell per cycle, then S_OUT
//   reverse of n elements: S_REV for n >= 2, one prefix rotation per cycle, then S_OUT
// Insert and remove shift the whole tail in a single update, each cell taking its
// neighbor's word. The response is held in output registers while rsp.ready is
// low, and no new request is taken until it is transferred.
// Reset (synchronous, active high) empties the vector; the element words keep
// arbitrary contents, and only entries below the count are ever read.
module bounded_vector_engine_top (
  input logic     clk,
  input logic     rst,
  bve_req_if.sink req,
  bve_rsp_if.source rsp
);
  import bve_pkg::*;

  state_e           state, state_next;
  logic [CNT_W-1:0] count;
  cell_op_e         op_r;
  logic [CMP_W-1:0] pos_r;
  logic [CMP_W-1:0] n_r;
  logic             find_r;
  logic             wave_r;
  logic             rev_r;
  logic [ELEM_W-1:0] key_r;
  logic [CMP_W-1:0] rev_j;
  logic [31:0]      read_word;
  logic [7:0]       found_position;
  status_e          status;

  logic             accept;
  cell_ctl_t        ctl;
  carry_t           chain_in;
  carry_t           carry [CAPACITY+1];
  logic [ELEM_W-1:0] words [CAPACITY];

  // Decode of the incoming request.
  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] pos_c;
  cell_op_e         d_op;
  logic [CMP_W-1:0] d_pos;
  logic             d_wave;
  logic             d_find;
  logic             d_rev;
  status_e          d_status;
  logic [CNT_W-1:0] d_count;

  assign accept = req.valid && req.ready;
  assign cnt_c  = CMP_W'(count);
  assign pos_c  = CMP_W'(req.position);

  always_comb begin
    d_op     = CELL_NOP;
    d_pos    = pos_c;
    d_wave   = 1'b0;
    d_find   = 1'b0;
    d_rev    = 1'b0;
    d_status = ST_OK;
    d_count  = count;
    case (req.req_type)
      REQ_APPEND: begin
        if (count >= CNT_W'(CAPACITY)) d_status = ST_FULL;
        else begin
          d_op    = CELL_LOAD;
          d_pos   = cnt_c;
          d_count = count + CNT_W'(1);
        end
      end
      REQ_POP, REQ_FRONT, REQ_BACK: begin
        if (count == '0) d_status = ST_EMPTY;
        else begin
          d_wave = 1'b1;
          d_pos  = (req.req_type == REQ_FRONT) ? '0 : cnt_c - CMP_W'(1);
          if (req.req_type == REQ_POP) d_count = count - CNT_W'(1);
        end
      end
      REQ_GET: begin
        if (pos_c >= cnt_c) d_status = ST_RANGE;
        else d_wave = 1'b1;
      end
      REQ_SET: begin
        if (pos_c >= cnt_c) d_status = ST_RANGE;
        else d_op = CELL_LOAD;
      end
      REQ_INSERT: begin
        if (pos_c >= cnt_c) d_status = ST_RANGE;
        else if (count >= CNT_W'(CAPACITY)) d_status = ST_FULL;
        else begin
          d_op    = CELL_INS;
          d_count = count + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (pos_c >= cnt_c) d_status = ST_RANGE;
        else begin
          d_op    = CELL_REM;
          d_count = count - CNT_W'(1);
        end
      end
      REQ_REVERSE: begin
        d_rev = count >= CNT_W'(2);
        d_pos = cnt_c - CMP_W'(1);
      end
      REQ_CLEAR: d_count = '0;
      REQ_FIND: begin
        d_wave = 1'b1;
        d_find = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid) state_next = S_EXEC;
      S_EXEC: begin
        if (wave_r) state_next = S_WAVE;
        else if (rev_r) state_next = S_REV;
        else state_next = S_OUT;
      end
      S_WAVE: if (carry[CAPACITY].valid) state_next = S_OUT;
      S_REV:  if (rev_j == CMP_W'(1)) state_next = S_OUT;
      S_OUT:  if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and cell control.
  always_comb begin
    req.ready      = state == S_IDLE;
    rsp.valid      = state == S_OUT;
    ctl.op         = CELL_NOP;
    ctl.pos        = pos_r;
    ctl.n          = n_r;
    ctl.find       = find_r;
    ctl.key        = key_r;
    chain_in.valid = 1'b0;
    chain_in.hit   = 1'b0;
    chain_in.data  = '0;
    chain_in.idx   = '0;
    case (state)
      S_EXEC: begin
        ctl.op         = op_r;
        chain_in.valid = wave_r;
      end
      S_REV: begin
        ctl.op  = CELL_ROT;
        ctl.pos = rev_j;
      end
      default: begin
      end
    endcase
  end

  assign rsp.read_word      = read_word;
  assign rsp.found_position = found_position;
  assign rsp.status         = status;
  assign rsp.count          = 9'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) count <= d_count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r           <= d_op;
      pos_r          <= d_pos;
      n_r            <= cnt_c;
      find_r         <= d_find;
      wave_r         <= d_wave;
      rev_r          <= d_rev;
      key_r          <= ELEM_W'(req.data_word);
      rev_j          <= d_pos;
      read_word      <= '0;
      found_position <= '0;
      status         <= d_status;
    end else if (state == S_REV) begin
      rev_j <= rev_j - CMP_W'(1);
    end else if (state == S_WAVE && carry[CAPACITY].valid) begin
      if (find_r) begin
        if (carry[CAPACITY].hit) begin
          found_position <= 8'(carry[CAPACITY].idx);
          status         <= ST_OK;
        end else begin
          status <= ST_NOTFOUND;
        end
      end else begin
        read_word <= 32'(carry[CAPACITY].data);
      end
    end
  end

  assign carry[0] = chain_in;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_W-1:0] left_w;
    logic [ELEM_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = words[i+1];
    end
    bve_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .my_idx    (IDX_W'(i)),
      .left_w    (left_w),
      .right_w   (right_w),
      .first_w   (words[0]),
      .carry_in  (carry[i]),
      .word      (words[i]),
      .carry_out (carry[i+1])
    );
  end

endmodule

[design/bve_checker.sv]
// Port-level checks of the bounded vector engine, bound to the top level.
module bve_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] read_word,
  input logic [2:0]  status,
  input logic [8:0]  count
);
  import bve_pkg::*;

  // A stalled response keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_word) && $stable(status)
      && $stable(count))
    else $error("response changed while stalled");

  // A request is never answered in the cycle right after its transfer.
  a_no_bypass: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid)
    else $error("response appeared too early");

  // One request at a time: no new request while a response is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while response pending");

  // Count never exceeds the capacity, and status is a defined code.
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (count <= 9'(CAPACITY)) && (status <= ST_NOTFOUND))
    else $error("count or status out of bounds");

endmodule

bind bounded_vector_engine_top bve_checker u_bve_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .read_word (rsp.read_word),
  .status    (rsp.status),
  .count     (rsp.count)
);
